// ===== rtl/lfuct_pkg.sv =====
// ----------------------------------------------------------------------------
// lfuct_pkg
// Shared constants and types of the LFU key-value table.
// ----------------------------------------------------------------------------
package lfuct_pkg;

  localparam int Entries   = 16;
  localparam int CountBits = 16;

  localparam int KeyW   = 32;
  localparam int DataW  = 32;
  localparam int StampW = 32;
  localparam int CfgW   = 5;

  localparam logic [CfgW-1:0] CapReset = CfgW'(16);

  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StResp
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

// ===== rtl/lfuct_store.sv =====
// ----------------------------------------------------------------------------
// lfuct_store
// Entry memory of the table: key, value, use count and stamp per slot in one
// synchronous RAM with registered read, plus a valid bit per slot.
// ----------------------------------------------------------------------------
module lfuct_store #(
  parameter int ENTRIES    = lfuct_pkg::Entries,
  parameter int COUNT_BITS = lfuct_pkg::CountBits,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfuct_pkg::store_ctl_t          ctl_i,
  input  logic [IW-1:0]                  rd_addr_i,
  input  logic [IW-1:0]                  wr_addr_i,
  input  logic [lfuct_pkg::KeyW-1:0]     wr_key_i,
  input  logic [lfuct_pkg::DataW-1:0]    wr_data_i,
  input  logic [COUNT_BITS-1:0]          wr_count_i,
  input  logic [lfuct_pkg::StampW-1:0]   wr_stamp_i,
  output logic                           rd_valid_o,
  output logic [lfuct_pkg::KeyW-1:0]     rd_key_o,
  output logic [lfuct_pkg::DataW-1:0]    rd_data_o,
  output logic [COUNT_BITS-1:0]          rd_count_o,
  output logic [lfuct_pkg::StampW-1:0]   rd_stamp_o
);

  localparam int EW = lfuct_pkg::KeyW + lfuct_pkg::DataW + COUNT_BITS + lfuct_pkg::StampW;

  logic [EW-1:0]      mem_q [ENTRIES];
  logic [EW-1:0]      rd_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= {wr_key_i, wr_data_i, wr_count_i, wr_stamp_i};
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign {rd_key_o, rd_data_o, rd_count_o, rd_stamp_o} = rd_q;

endmodule

// ===== rtl/lfu_cache_table.sv =====
// A request (get or put) runs as follows from acceptance to result: every
// slot is read once through the single read port of the entry RAM while key
// match, least-used victim and first free slot are tracked, the last slot read
// is then checked, any entry that the request changes is written back and the
// result register is loaded. A new request is taken only once the previous
// result has moved into the result register; that register lets it start while
// the last result still waits for out_ready_i.
// ----------------------------------------------------------------------------
// lfu_cache_table
// LFU key-value table with least-recently-used tie break and saturating counts.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int ENTRIES    = lfuct_pkg::Entries,
  parameter int COUNT_BITS = lfuct_pkg::CountBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfuct_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [lfuct_pkg::KeyW-1:0]          lookup_key_i,
  input  logic signed [lfuct_pkg::DataW-1:0]  write_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic signed [lfuct_pkg::DataW-1:0]  read_value_o,
  output logic                                evicted_o,
  output logic [lfuct_pkg::KeyW-1:0]          evicted_key_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > lfuct_pkg::CfgW) ? CW : lfuct_pkg::CfgW;
  localparam int KW = lfuct_pkg::KeyW;
  localparam int DW = lfuct_pkg::DataW;
  localparam int SW = lfuct_pkg::StampW;

  lfuct_pkg::state_e state_q, state_d;

  logic [lfuct_pkg::CfgW-1:0] cap_q;
  logic [CW-1:0]              occ_q, occ_d;
  logic [SW-1:0]              clock_q, clock_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [IW-1:0]              chk_idx_q;

  logic          req_put_q;
  logic [KW-1:0] req_key_q;
  logic [DW-1:0] req_val_q;

  // scan results
  logic                  hit_q, hit_d;
  logic [IW-1:0]         hit_idx_q, hit_idx_d;
  logic [DW-1:0]         hit_data_q, hit_data_d;
  logic [COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;
  logic                  vic_q, vic_d;
  logic [IW-1:0]         vic_idx_q, vic_idx_d;
  logic [KW-1:0]         vic_key_q, vic_key_d;
  logic [COUNT_BITS-1:0] vic_cnt_q, vic_cnt_d;
  logic [SW-1:0]         vic_stamp_q, vic_stamp_d;
  logic                  free_q, free_d;
  logic [IW-1:0]         free_idx_q, free_idx_d;

  // pending result
  logic          res_hit_q, res_hit_d;
  logic [DW-1:0] res_rdata_q, res_rdata_d;
  logic          res_evict_q, res_evict_d;
  logic [KW-1:0] res_ekey_q, res_ekey_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic          o_hit_q;
  logic [DW-1:0] o_rdata_q;
  logic          o_evict_q;
  logic [KW-1:0] o_ekey_q;

  lfuct_pkg::store_ctl_t ctl;
  logic [IW-1:0]         wr_addr;
  logic [KW-1:0]         wr_key;
  logic [DW-1:0]         wr_data;
  logic [COUNT_BITS-1:0] wr_count;
  logic                  rd_valid;
  logic [KW-1:0]         rd_key;
  logic [DW-1:0]         rd_data;
  logic [COUNT_BITS-1:0] rd_count;
  logic [SW-1:0]         rd_stamp;

  logic          accept;
  logic [XW-1:0] eff_cap;
  logic [XW-1:0] cap_x;
  logic [XW-1:0] occ_x;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == lfuct_pkg::StIdle);

  assign cap_x   = XW'(cap_q);
  assign occ_x   = XW'(occ_q);
  assign eff_cap = (cap_x > XW'(ENTRIES)) ? XW'(ENTRIES) : cap_x;

  lfuct_store #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rd_addr_i  (cnt_q[IW-1:0]),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (wr_key),
    .wr_data_i  (wr_data),
    .wr_count_i (wr_count),
    .wr_stamp_i (clock_q),
    .rd_valid_o (rd_valid),
    .rd_key_o   (rd_key),
    .rd_data_o  (rd_data),
    .rd_count_o (rd_count),
    .rd_stamp_o (rd_stamp)
  );

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    clock_d     = clock_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_data_d  = hit_data_q;
    hit_cnt_d   = hit_cnt_q;
    vic_d       = vic_q;
    vic_idx_d   = vic_idx_q;
    vic_key_d   = vic_key_q;
    vic_cnt_d   = vic_cnt_q;
    vic_stamp_d = vic_stamp_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    res_hit_d   = res_hit_q;
    res_rdata_d = res_rdata_q;
    res_evict_d = res_evict_q;
    res_ekey_d  = res_ekey_q;
    out_load    = 1'b0;
    ctl         = '0;
    wr_addr     = hit_idx_q;
    wr_key      = req_key_q;
    wr_data     = req_val_q;
    wr_count    = COUNT_BITS'(1);

    // compare the entry read in the previous cycle
    if (chk_vld_q) begin
      if (rd_valid) begin
        if (!hit_q && rd_key == req_key_q) begin
          hit_d      = 1'b1;
          hit_idx_d  = chk_idx_q;
          hit_data_d = rd_data;
          hit_cnt_d  = rd_count;
        end
        if (!vic_q || rd_count < vic_cnt_q ||
            (rd_count == vic_cnt_q && rd_stamp < vic_stamp_q)) begin
          vic_d       = 1'b1;
          vic_idx_d   = chk_idx_q;
          vic_key_d   = rd_key;
          vic_cnt_d   = rd_count;
          vic_stamp_d = rd_stamp;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end

    unique case (state_q)
      lfuct_pkg::StIdle: begin
        if (accept) begin
          state_d = lfuct_pkg::StScan;
          cnt_d   = '0;
          hit_d   = 1'b0;
          vic_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      lfuct_pkg::StScan: begin
        if (cnt_q != CW'(ENTRIES)) begin
          ctl.rd_en = 1'b1;
          chk_vld_d = 1'b1;
          cnt_d     = cnt_q + CW'(1);
        end else begin
          state_d = lfuct_pkg::StUpdate;
        end
      end
      lfuct_pkg::StUpdate: begin
        state_d     = lfuct_pkg::StResp;
        res_hit_d   = 1'b0;
        res_rdata_d = '0;
        res_evict_d = 1'b0;
        res_ekey_d  = '0;
        if (hit_q) begin
          res_hit_d = 1'b1;
          if (req_put_q == lfuct_pkg::ReqGet) begin
            res_rdata_d = hit_data_q;
            wr_data     = hit_data_q;
          end
          wr_addr   = hit_idx_q;
          wr_count  = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);
          ctl.wr_en = 1'b1;
          clock_d   = clock_q + SW'(1);
        end else if (req_put_q == lfuct_pkg::ReqPut && eff_cap != '0) begin
          if (occ_x >= eff_cap) begin
            if (vic_q) begin
              res_evict_d = 1'b1;
              res_ekey_d  = vic_key_q;
              wr_addr     = vic_idx_q;
              ctl.wr_en   = 1'b1;
              clock_d     = clock_q + SW'(1);
            end
          end else if (free_q) begin
            wr_addr   = free_idx_q;
            ctl.wr_en = 1'b1;
            clock_d   = clock_q + SW'(1);
            occ_d     = occ_q + CW'(1);
          end
        end
      end
      lfuct_pkg::StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = lfuct_pkg::StIdle;
        end
      end
      default: state_d = lfuct_pkg::StIdle;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfuct_pkg::StIdle;
      cap_q       <= lfuct_pkg::CapReset;
      occ_q       <= '0;
      clock_q     <= '0;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      vic_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      occ_q       <= occ_d;
      clock_q     <= clock_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      vic_q       <= vic_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= cnt_q[IW-1:0];
    hit_idx_q   <= hit_idx_d;
    hit_data_q  <= hit_data_d;
    hit_cnt_q   <= hit_cnt_d;
    vic_idx_q   <= vic_idx_d;
    vic_key_q   <= vic_key_d;
    vic_cnt_q   <= vic_cnt_d;
    vic_stamp_q <= vic_stamp_d;
    free_idx_q  <= free_idx_d;
    res_hit_q   <= res_hit_d;
    res_rdata_q <= res_rdata_d;
    res_evict_q <= res_evict_d;
    res_ekey_q  <= res_ekey_d;
    if (accept) begin
      req_put_q <= req_type_i;
      req_key_q <= lookup_key_i;
      req_val_q <= write_value_i;
    end
    if (out_load) begin
      o_hit_q   <= res_hit_q;
      o_rdata_q <= res_rdata_q;
      o_evict_q <= res_evict_q;
      o_ekey_q  <= res_ekey_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = o_hit_q;
  assign read_value_o  = $signed(o_rdata_q);
  assign evicted_o     = o_evict_q;
  assign evicted_key_o = o_ekey_q;

endmodule

// ===== rtl/lfuct_checker.sv =====
// ----------------------------------------------------------------------------
// lfuct_checker
// Port-level checks of the LFU key-value table, bound to the top level.
// ----------------------------------------------------------------------------
module lfuct_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                hit_o,
  input logic signed [lfuct_pkg::DataW-1:0]  read_value_o,
  input logic                                evicted_o,
  input logic [lfuct_pkg::KeyW-1:0]          evicted_key_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(hit_o) && $stable(read_value_o) &&
      $stable(evicted_o) && $stable(evicted_key_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o)
    else $error("eviction on a hit");

  a_value_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_value_o != '0 |-> hit_o && !evicted_o)
    else $error("read value without hit");

  a_ekey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_key_o == '0)
    else $error("evicted key without eviction");

endmodule

bind lfu_cache_table lfuct_checker u_lfuct_checker (.*);

// ===== tb/tb_lfu_cache_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lfu_cache_table
// Self-checking bench for the LFU key-value table. A directed table covers
// reset, field extremes, update of a present key, eviction, zero and
// oversized capacity and capacity lowered below occupancy. Random phases
// follow, each setting a capacity and one of four idle and stall patterns.
// Every result is checked against a cycle-free mirror of the table.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;

  localparam logic [lfuct_pkg::CountBits-1:0] CountMax = '1;
  localparam int PhaseItems = 200;
  localparam int NumPhases  = 8;
  localparam int PoolSize   = 24;
  localparam int StallLimit = 4000;

  typedef struct packed {
    logic                               hit;
    logic signed [lfuct_pkg::DataW-1:0] read_value;
    logic                               evicted;
    logic [lfuct_pkg::KeyW-1:0]         evicted_key;
  } resp_t;

  typedef enum logic {OpReq, OpCap} row_op_e;

  typedef struct packed {
    row_op_e                     op;
    logic                        rtype;
    logic [lfuct_pkg::KeyW-1:0]  key;
    logic [lfuct_pkg::DataW-1:0] val;
    logic                        fixed;
    resp_t                       exp;
  } dir_row_t;

  localparam resp_t NoResp = '0;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [lfuct_pkg::CfgW-1:0]         cfg_wdata_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic                               req_type_i;
  logic [lfuct_pkg::KeyW-1:0]         lookup_key_i;
  logic signed [lfuct_pkg::DataW-1:0] write_value_i;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic                               hit_o;
  logic signed [lfuct_pkg::DataW-1:0] read_value_o;
  logic                               evicted_o;
  logic [lfuct_pkg::KeyW-1:0]         evicted_key_o;

  lfu_cache_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .lookup_key_i (lookup_key_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o)
  );

  always #1 clk_i = ~clk_i;

  // mirror of the table
  logic                            m_valid [lfuct_pkg::Entries];
  logic [lfuct_pkg::KeyW-1:0]      m_key   [lfuct_pkg::Entries];
  logic [lfuct_pkg::DataW-1:0]     m_data  [lfuct_pkg::Entries];
  logic [lfuct_pkg::CountBits-1:0] m_count [lfuct_pkg::Entries];
  logic [lfuct_pkg::StampW-1:0]    m_stamp [lfuct_pkg::Entries];
  logic [lfuct_pkg::StampW-1:0]    m_clock = '0;
  int unsigned                     m_occ = 0;
  logic [lfuct_pkg::CfgW-1:0]      m_cap = lfuct_pkg::CapReset;

  resp_t resp_q [$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    stall_cnt = 0;

  dir_row_t dir_tab [25] = '{
    '{OpReq, lfuct_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b1, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0000, 32'h7fff_ffff, 1'b1, NoResp},
    '{OpReq, lfuct_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'sh7fff_ffff, 1'b0, 32'h0}},
    '{OpReq, lfuct_pkg::ReqPut, 32'hffff_ffff, 32'h8000_0000, 1'b1, NoResp},
    '{OpReq, lfuct_pkg::ReqGet, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
      '{1'b1, 32'sh8000_0000, 1'b0, 32'h0}},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0000, 32'hffff_ffff, 1'b1,
      '{1'b1, 32'sh0, 1'b0, 32'h0}},
    '{OpReq, lfuct_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'shffff_ffff, 1'b0, 32'h0}},
    '{OpCap, lfuct_pkg::ReqGet, 32'h0, 32'd2, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0005, 32'h0000_0001, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqGet, 32'hffff_ffff, 32'h0000_0000, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0006, 32'h0000_0002, 1'b0, NoResp},
    '{OpCap, lfuct_pkg::ReqGet, 32'h0, 32'd0, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0007, 32'h1234_5678, 1'b1, NoResp},
    '{OpReq, lfuct_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0000, 32'h0000_007b, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqGet, 32'h0000_0007, 32'h0000_0000, 1'b1, NoResp},
    '{OpCap, lfuct_pkg::ReqGet, 32'h0, 32'd31, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0064, 32'ha5a5_a5a5, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0065, 32'h5a5a_5a5a, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_0066, 32'h0000_0066, 1'b0, NoResp},
    '{OpCap, lfuct_pkg::ReqGet, 32'h0, 32'd1, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_00c8, 32'h0000_00c8, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqPut, 32'h0000_00c9, 32'h0000_00c9, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqGet, 32'h0000_00c8, 32'h0000_0000, 1'b0, NoResp},
    '{OpReq, lfuct_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b0, NoResp}
  };

  logic [lfuct_pkg::CfgW-1:0] phase_cap [NumPhases] = '{
    5'd16, 5'd5, 5'd1, 5'd0, 5'd31, 5'd12, 5'd3, 5'd16
  };

  task automatic lfu_predict(input logic rtype, input logic [lfuct_pkg::KeyW-1:0] key,
                             input logic [lfuct_pkg::DataW-1:0] val, output resp_t r);
    int idx;
    int slot;
    int unsigned cap;
    r = '0;
    cap = (m_cap > lfuct_pkg::Entries) ? lfuct_pkg::Entries : m_cap;
    idx = -1;
    for (int i = 0; i < lfuct_pkg::Entries; i++) begin
      if (idx < 0 && m_valid[i] && m_key[i] == key) idx = i;
    end
    if (idx >= 0) begin
      r.hit = 1'b1;
      if (rtype == lfuct_pkg::ReqPut) m_data[idx] = val;
      else r.read_value = m_data[idx];
      if (m_count[idx] != CountMax) m_count[idx] = m_count[idx] + 1'b1;
      m_stamp[idx] = m_clock;
      m_clock = m_clock + 1'b1;
    end else if (rtype == lfuct_pkg::ReqPut && cap != 0) begin
      slot = -1;
      if (m_occ >= cap) begin
        // least used, then oldest stamp, then lowest slot
        for (int i = 0; i < lfuct_pkg::Entries; i++) begin
          if (m_valid[i] && (slot < 0 || m_count[i] < m_count[slot] ||
              (m_count[i] == m_count[slot] && m_stamp[i] < m_stamp[slot])))
            slot = i;
        end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = m_key[slot];
        end
      end else begin
        for (int i = 0; i < lfuct_pkg::Entries; i++) begin
          if (slot < 0 && !m_valid[i]) slot = i;
        end
        if (slot >= 0) m_occ++;
      end
      if (slot >= 0) begin
        m_valid[slot] = 1'b1;
        m_key[slot]   = key;
        m_data[slot]  = val;
        m_count[slot] = {{(lfuct_pkg::CountBits-1){1'b0}}, 1'b1};
        m_stamp[slot] = m_clock;
        m_clock = m_clock + 1'b1;
      end
    end
  endtask

  task automatic send_req(input logic rtype, input logic [lfuct_pkg::KeyW-1:0] key,
                          input logic [lfuct_pkg::DataW-1:0] val, input logic fixed,
                          input resp_t fixed_resp);
    resp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rtype;
    lookup_key_i  <= key;
    write_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    lfu_predict(rtype, key, val, r);
    resp_q.push_back(fixed ? fixed_resp : r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (resp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [lfuct_pkg::CfgW-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_cap = cap;
  endtask

  function automatic void chk_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns mismatch on %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // response ready with random stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (resp_q.size() == 0) begin
        $display("%0t ns unexpected response: hit %b value %h evicted %b key %h",
                 $time, hit_o, read_value_o, evicted_o, evicted_key_o);
        errors++;
      end else begin
        want = resp_q.pop_front();
        chk_field("hit", 32'(want.hit), 32'(hit_o));
        chk_field("read_value", want.read_value, read_value_o);
        chk_field("evicted", 32'(want.evicted), 32'(evicted_o));
        chk_field("evicted_key", want.evicted_key, evicted_key_o);
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t ns watchdog: no request or response moved for %0d cycles",
               $time, StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    logic [lfuct_pkg::KeyW-1:0] key_pool [PoolSize];
    logic [lfuct_pkg::KeyW-1:0] k;
    for (int i = 0; i < lfuct_pkg::Entries; i++) begin
      m_valid[i] = 1'b0;
      m_key[i]   = '0;
      m_data[i]  = '0;
      m_count[i] = '0;
      m_stamp[i] = '0;
    end
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    req_type_i    = lfuct_pkg::ReqGet;
    lookup_key_i  = '0;
    write_value_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == OpCap) set_capacity(dir_tab[i].val[lfuct_pkg::CfgW-1:0]);
      else send_req(dir_tab[i].rtype, dir_tab[i].key, dir_tab[i].val,
                    dir_tab[i].fixed, dir_tab[i].exp);
    end

    for (int p = 0; p < NumPhases; p++) begin
      set_capacity(phase_cap[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int j = 0; j < PoolSize; j++) key_pool[j] = $urandom();
      for (int n = 0; n < PhaseItems; n++) begin
        // sender holds off until the table has answered everything
        if (n == PhaseItems / 2 || $urandom_range(199) == 0) wait_drained();
        if ($urandom_range(9) == 0) k = $urandom();
        else if ($urandom_range(1) == 1) k = key_pool[$urandom_range(5)];
        else k = key_pool[$urandom_range(PoolSize - 1)];
        send_req(($urandom_range(1) == 1) ? lfuct_pkg::ReqPut : lfuct_pkg::ReqGet,
                 k, $urandom(), 1'b0, NoResp);
      end
    end

    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (lfuct_pkg::Entries + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lfuct_pkg.sv
rtl/lfuct_store.sv
rtl/lfu_cache_table.sv
rtl/lfuct_checker.sv
tb/tb_lfu_cache_table.sv
